>>> src/tpr_pkg.sv
// shared types and constants for the tolerance point registry
package tpr_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int CW_COORD      = 32;
    localparam int TOL_W         = 31;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;
    localparam int DIST_LAT      = 3;

    typedef enum logic [1:0] {
        OP_GET_OR_CREATE = 2'd0,
        OP_CREATE        = 2'd1,
        OP_FIND_POS      = 2'd2,
        OP_FIND_ID       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_MATCH    = 2'd0,
        ST_CREATED  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [CW_COORD-1:0] x;
        logic signed [CW_COORD-1:0] y;
        logic signed [CW_COORD-1:0] z;
    } t_point;

    typedef struct packed {
        logic valid;
        logic in_tol;
    } t_dist_flags;

endpackage

>>> src/tolerance_point_registry.sv
// top level: point registry with a rotating ring of point cells
// create skips the scan and goes from idle straight to the finish state; other ops scan the ring first
// the ring rotates once through the distance pipeline, then the pipeline drains
// one request in flight at a time
// reset clears node count, fsm and output valid; tolerance resets to 66
// stored points are not cleared, slots at or above the node count are never used
module tolerance_point_registry #(
    parameter int MAX_NODES = tpr_pkg::MAX_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic [15:0] i_query_id,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_node_id,
    output logic signed [31:0] o_node_x,
    output logic signed [31:0] o_node_y,
    output logic signed [31:0] o_node_z,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tpr_pkg::*;

    localparam int SW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int KW = $clog2(MAX_NODES + DIST_LAT + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state          r_state;
    logic [TOL_W-1:0] r_tol;
    logic [61:0]     r_tt;
    logic [CW-1:0]   r_count;
    logic [KW-1:0]   r_cnt;
    t_op             r_op;
    t_point          r_query;
    logic [15:0]     r_qid;
    logic            r_hit;
    logic [SW-1:0]   r_hit_slot;
    t_point          r_hit_pt;

    logic            r_ovalid;
    logic [1:0]      r_ostatus;
    logic [15:0]     r_oid;
    t_point          r_opt;

    t_point          w_pt [MAX_NODES];
    logic            w_shift;
    logic            w_issue;
    logic            w_append;
    logic            w_room;
    logic            w_out_free;
    logic            w_capture;
    t_dist_flags     w_flags;
    logic [SW-1:0]   w_slot;
    t_point          w_dpt;
    t_point          w_in_pt;

    // apb: one register at byte address 0, aliased wherever paddr[2] is low
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {1'b0, r_tol} : 32'd0;

    assign w_in_pt.x = i_coord_x;
    assign w_in_pt.y = i_coord_y;
    assign w_in_pt.z = i_coord_z;

    assign o_ready    = (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || i_ready;
    // ring rotates once per scan so it comes back aligned
    assign w_issue    = (r_state == S_SCAN) && (r_cnt < KW'(MAX_NODES));
    assign w_shift    = w_issue;
    assign w_room     = r_count < CW'(MAX_NODES);
    assign w_append   = (r_state == S_FIN) && w_out_free && !r_hit && w_room &&
                        ((r_op == OP_GET_OR_CREATE) || (r_op == OP_CREATE));

    // ring of point cells, cell 0 is the head seen by the distance unit
    for (genvar gi = 0; gi < MAX_NODES; gi++) begin : g_ring
        tpr_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_shift),
            .i_next    (w_pt[(gi + 1) % MAX_NODES]),
            .i_load    (w_append && (r_count == CW'(gi))),
            .i_load_pt (r_query),
            .o_pt      (w_pt[gi])
        );
    end

    tpr_dist #(.SW(SW)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_issue),
        .i_slot  (r_cnt[SW-1:0]),
        .i_cell  (w_pt[0]),
        .i_query (r_query),
        .i_tt    (r_tt),
        .o_flags (w_flags),
        .o_slot  (w_slot),
        .o_pt    (w_dpt)
    );

    // first hit wins; find by id matches on slot number instead of distance
    always_comb begin
        if (r_op == OP_FIND_ID) begin
            w_capture = (r_qid != 16'd0) && ({1'b0, r_qid} <= 17'(r_count)) &&
                        (17'(w_slot) == ({1'b0, r_qid} - 17'd1));
        end else begin
            w_capture = w_flags.in_tol && (CW'(w_slot) < r_count);
        end
        w_capture = w_capture && w_flags.valid && !r_hit && (r_state == S_SCAN);
    end

    always_ff @(posedge i_clk) begin
        r_tt <= r_tol * r_tol;
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cnt    <= '0;
            r_hit    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // in the finish state the output register is refilled below
            if (r_ovalid && i_ready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= t_op'(i_operation);
                        r_query <= w_in_pt;
                        r_qid   <= i_query_id;
                        r_hit   <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= (t_op'(i_operation) == OP_CREATE) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_capture) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= w_slot;
                        r_hit_pt   <= w_dpt;
                    end
                    if (r_cnt == KW'(MAX_NODES + DIST_LAT)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + KW'(1);
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                        if (r_hit) begin
                            r_ostatus <= ST_MATCH;
                            r_oid     <= 16'(r_hit_slot) + 16'd1;
                            r_opt     <= r_hit_pt;
                        end else if (w_append) begin
                            r_ostatus <= ST_CREATED;
                            r_oid     <= 16'(r_count) + 16'd1;
                            r_opt     <= r_query;
                            r_count   <= r_count + CW'(1);
                        end else begin
                            r_ostatus <= ((r_op == OP_GET_OR_CREATE) || (r_op == OP_CREATE))
                                         ? ST_FULL : ST_NOTFOUND;
                            r_oid     <= 16'd0;
                            r_opt     <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid   = r_ovalid;
    assign o_status  = r_ostatus;
    assign o_node_id = r_oid;
    assign o_node_x  = r_opt.x;
    assign o_node_y  = r_opt.y;
    assign o_node_z  = r_opt.z;
endmodule

>>> src/tpr_cell.sv
// one ring cell holding a stored point
module tpr_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  tpr_pkg::t_point i_next,
    input  logic           i_load,
    input  tpr_pkg::t_point i_load_pt,
    output tpr_pkg::t_point o_pt
);
    import tpr_pkg::*;

    t_point r_pt;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pt <= i_load_pt;
        end else if (i_shift) begin
            r_pt <= i_next;
        end
    end

    assign o_pt = r_pt;
endmodule

>>> src/tpr_dist.sv
// pipelined squared distance test against the tolerance
module tpr_dist #(
    parameter int SW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_issue,
    input  logic [SW-1:0]         i_slot,
    input  tpr_pkg::t_point       i_cell,
    input  tpr_pkg::t_point       i_query,
    input  logic [61:0]           i_tt,
    output tpr_pkg::t_dist_flags  o_flags,
    output logic [SW-1:0]         o_slot,
    output tpr_pkg::t_point       o_pt
);
    import tpr_pkg::*;

    logic          r_v1, r_v2, r_v3;
    logic [SW-1:0] r_s1, r_s2, r_s3;
    t_point        r_p1, r_p2, r_p3;
    logic          r_far1, r_far2;
    logic [30:0]   r_ax, r_ay, r_az;
    logic [61:0]   r_sx, r_sy, r_sz;
    logic          r_in_tol;

    logic signed [32:0] w_dx, w_dy, w_dz;
    logic [32:0]        w_ax, w_ay, w_az;
    logic [63:0]        w_sum;

    always_comb begin
        w_dx = {i_cell.x[31], i_cell.x} - {i_query.x[31], i_query.x};
        w_dy = {i_cell.y[31], i_cell.y} - {i_query.y[31], i_query.y};
        w_dz = {i_cell.z[31], i_cell.z} - {i_query.z[31], i_query.z};
        w_ax = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
        w_ay = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
        w_az = w_dz[32] ? 33'(-w_dz) : 33'(w_dz);
        w_sum = {2'b00, r_sx} + {2'b00, r_sy} + {2'b00, r_sz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        // axis differences, far flag
        r_s1   <= i_slot;
        r_p1   <= i_cell;
        r_far1 <= (|w_ax[32:31]) | (|w_ay[32:31]) | (|w_az[32:31]);
        r_ax   <= w_ax[30:0];
        r_ay   <= w_ay[30:0];
        r_az   <= w_az[30:0];
        // squares
        r_s2   <= r_s1;
        r_p2   <= r_p1;
        r_far2 <= r_far1;
        r_sx   <= r_ax * r_ax;
        r_sy   <= r_ay * r_ay;
        r_sz   <= r_az * r_az;
        // sum and compare
        r_s3     <= r_s2;
        r_p3     <= r_p2;
        r_in_tol <= !r_far2 && (w_sum < {2'b00, i_tt});
    end

    assign o_flags.valid  = r_v3;
    assign o_flags.in_tol = r_in_tol;
    assign o_slot         = r_s3;
    assign o_pt           = r_p3;
endmodule

>>> tb/tolerance_point_registry_tb.sv
// testbench for the tolerance point registry: directed and random beats checked against a predictor
module tolerance_point_registry_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpr_pkg::*;

    localparam int NODES = MAX_NODES_DEF;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] id;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_result;

    // scoreboard: predicts each result from the registry contents and checks outputs in order
    class registry_scoreboard;
        logic [31:0] px[NODES];
        logic [31:0] py[NODES];
        logic [31:0] pz[NODES];
        int          count;
        logic [30:0] radius;
        t_result     pending[$];
        int          errors;

        function void clear();
            count = 0;
            radius = TOL_RESET;
            errors = 0;
        endfunction

        function bit near(int s, logic [31:0] x, logic [31:0] y, logic [31:0] z);
            longint dx, dy, dz;
            longint unsigned r;
            dx = longint'($signed(px[s])) - longint'($signed(x));
            dy = longint'($signed(py[s])) - longint'($signed(y));
            dz = longint'($signed(pz[s])) - longint'($signed(z));
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dz < 0) dz = -dz;
            if (dx >= 64'h8000_0000 || dy >= 64'h8000_0000 || dz >= 64'h8000_0000)
                return 0;
            r = radius;
            // the sum of squares can pass 2^63, so compare unsigned
            return ($unsigned(dx * dx) + $unsigned(dy * dy) + $unsigned(dz * dz)) < (r * r)
                   ? 1'b1 : 1'b0;
        endfunction

        function t_result hit(logic [1:0] st, int s);
            t_result r;
            r.status = st;
            r.id = 16'(s + 1);
            r.x = px[s];
            r.y = py[s];
            r.z = pz[s];
            return r;
        endfunction

        function t_result none(logic [1:0] st);
            t_result r;
            r.status = st;
            r.id = 0;
            r.x = 0;
            r.y = 0;
            r.z = 0;
            return r;
        endfunction

        function t_result insert(logic [31:0] x, logic [31:0] y, logic [31:0] z);
            if (count >= NODES) return none(ST_FULL);
            px[count] = x;
            py[count] = y;
            pz[count] = z;
            count++;
            return hit(ST_CREATED, count - 1);
        endfunction

        function int first_near(logic [31:0] x, logic [31:0] y, logic [31:0] z);
            for (int i = 0; i < count; i++)
                if (near(i, x, y, z)) return i;
            return -1;
        endfunction

        function void note_request(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                   logic [31:0] z, logic [15:0] qid);
            int s;
            t_result r;
            case (t_op'(op))
                OP_GET_OR_CREATE: begin
                    s = first_near(x, y, z);
                    r = (s >= 0) ? hit(ST_MATCH, s) : insert(x, y, z);
                end
                OP_CREATE: r = insert(x, y, z);
                OP_FIND_POS: begin
                    s = first_near(x, y, z);
                    r = (s >= 0) ? hit(ST_MATCH, s) : none(ST_NOTFOUND);
                end
                default: begin
                    if (qid >= 1 && qid <= count) r = hit(ST_MATCH, int'(qid) - 1);
                    else r = none(ST_NOTFOUND);
                end
            endcase
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d id=%0d", $realtime, got.status,
                         got.id);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", $realtime, e.status, got.status);
                errors++;
            end
            if (got.id !== e.id) begin
                $display("%0t: node_id exp %0d got %0d", $realtime, e.id, got.id);
                errors++;
            end
            if (got.x !== e.x) begin
                $display("%0t: node_x exp %h got %h", $realtime, e.x, got.x);
                errors++;
            end
            if (got.y !== e.y) begin
                $display("%0t: node_y exp %h got %h", $realtime, e.y, got.y);
                errors++;
            end
            if (got.z !== e.z) begin
                $display("%0t: node_z exp %h got %h", $realtime, e.z, got.z);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = '0;
    logic signed [31:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic [15:0] i_query_id = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_node_id;
    logic signed [31:0] o_node_x, o_node_y, o_node_z;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tolerance_point_registry u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    registry_scoreboard board;
    int  send_idle_pct = 0;   // chance in percent that the sender idles a cycle
    int  recv_stall_pct = 0;  // chance in percent that the receiver stalls a cycle
    bit  hold_off = 1'b0;     // long receiver stall for back pressure
    int  quiet_cycles = 0;

    // receiver side: sample results at the rising edge, retime ready at the falling one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result('{o_status, o_node_id, o_node_x, o_node_y, o_node_z});
    end

    always @(negedge i_clk) begin
        i_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: counts cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one request beat; the prediction is taken when the beat is accepted
    // valid drops only when the sender idles or the run moves on
    task automatic send_request(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z, logic [15:0] qid);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        i_query_id <= qid;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(op, x, y, z, qid);
        @(negedge i_clk);
    endtask

    // apb write with setup and access phases, only while idle
    task automatic write_tolerance(logic [30:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {1'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.radius = value;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (NODES + 10) @(negedge i_clk);
    endtask

    // random coordinate, mostly clustered so that matches happen, sometimes full range
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0, 1: return $urandom();
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(400)) - 200);
        endcase
    endfunction

    task automatic random_beats(int n);
        logic [31:0] x, y, z;
        int s;
        for (int k = 0; k < n; k++) begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
            // often query near a stored point to exercise matching
            if (board.count > 0 && $urandom_range(2) == 0) begin
                s = $urandom_range(board.count - 1);
                x = board.px[s] + 32'($signed($urandom_range(60)) - 30);
                y = board.py[s];
                z = board.pz[s] + 32'($signed($urandom_range(20)) - 10);
            end
            send_request(2'($urandom_range(3)), x, y, z,
                         $urandom_range(3) == 0 ? 16'($urandom()) :
                         16'($urandom_range(board.count + 2)));
        end
    endtask

    initial begin
        board = new();
        board.clear();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: lookups on an empty table, extremes, reset radius boundary
        send_request(OP_FIND_ID, 0, 0, 0, 16'd0);
        send_request(OP_FIND_POS, 0, 0, 0, 16'd0);
        send_request(OP_GET_OR_CREATE, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_request(OP_GET_OR_CREATE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_request(OP_GET_OR_CREATE, 0, 0, 0, 16'hffff);
        send_request(OP_GET_OR_CREATE, 65, 0, 0, 0);   // within 66 of origin
        send_request(OP_FIND_POS, 66, 0, 0, 0);        // exactly on the radius, no match
        send_request(OP_FIND_POS, 38, 38, 38, 0);
        send_request(OP_CREATE, 0, 0, 0, 0);
        send_request(OP_FIND_ID, 0, 0, 0, 16'd4);
        send_request(OP_FIND_ID, 0, 0, 0, 16'd5);
        send_request(OP_FIND_ID, 0, 0, 0, 16'hffff);
        send_request(OP_FIND_ID, 0, 0, 0, 16'd1);
        drain();
        // zero radius: nothing ever matches
        write_tolerance(31'd0);
        send_request(OP_FIND_POS, 0, 0, 0, 0);
        send_request(OP_GET_OR_CREATE, 0, 0, 0, 0);
        drain();
        // widest radius: almost everything matches
        write_tolerance(31'h7fff_ffff);
        send_request(OP_FIND_POS, 32'h4000_0000, 32'hc000_0000, 32'h1234_5678, 0);
        send_request(OP_GET_OR_CREATE, 32'h8000_0000, 0, 0, 0);
        drain();
        write_tolerance(31'd50);

        // random phases over the idling mixes
        send_idle_pct = 0;  recv_stall_pct = 0;  random_beats(250);
        send_idle_pct = 50; recv_stall_pct = 0;  random_beats(150);
        drain();
        write_tolerance(31'd300);
        send_idle_pct = 0;  recv_stall_pct = 50; random_beats(150);
        send_idle_pct = 31; recv_stall_pct = 31; random_beats(150);

        // back pressure: receiver holds off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            random_beats(6);
        join

        // fill the table to the top and keep creating to hit the full case
        send_idle_pct = 0; recv_stall_pct = 0;
        while (board.count < NODES)
            send_request(OP_CREATE, $urandom(), $urandom(), $urandom(), 0);
        for (int k = 0; k < 10; k++)
            send_request(OP_GET_OR_CREATE, $urandom(), $urandom(), $urandom(), 0);
        send_request(OP_FIND_ID, 0, 0, 0, 16'd256);
        send_request(OP_FIND_ID, 0, 0, 0, 16'd257);
        drain();
        write_tolerance(31'($urandom()));
        send_idle_pct = 31; recv_stall_pct = 31; random_beats(300);
        drain();
        write_tolerance(31'd100000);
        send_idle_pct = 0; recv_stall_pct = 50; random_beats(400);
        send_idle_pct = 50; recv_stall_pct = 0; random_beats(500);

        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
